// File: rtl/upsm_pkg.sv
// ----------------------------------------------------------------------------
// upsm_pkg
// Shared types and codes for the PCM to mono 44.1 kHz upsampler.
// ----------------------------------------------------------------------------
package upsm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIXTEEN_BIT = 2'd0,
    CFG_STEREO      = 2'd1,
    CFG_RATE_SELECT = 2'd2
  } cfg_idx_t;

  // Source rate codes; the unused code behaves as 11025 Hz.
  localparam logic [1:0] RATE_44100 = 2'd0;
  localparam logic [1:0] RATE_22050 = 2'd1;
  localparam logic [1:0] RATE_11025 = 2'd2;

  localparam logic [7:0] SIGN_FLIP_8 = 8'h80;

  typedef struct packed {
    logic       sixteen_bit;
    logic       stereo;
    logic [1:0] rate_select;
  } cfg_t;

  typedef struct packed {
    logic [15:0] left_raw;
    logic [15:0] right_raw;
    logic        clip_last;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] audio_out;
    logic               clip_done;
  } out_item_t;

  // One interpolation job: expand cur towards nxt.
  typedef struct packed {
    logic signed [15:0] cur;
    logic signed [15:0] nxt;
    logic               done;
  } job_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: rtl/upsm_fifo.sv
// ----------------------------------------------------------------------------
// upsm_fifo
// Small register queue of interpolation jobs between front and back.
// ----------------------------------------------------------------------------
module upsm_fifo import upsm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       head_job,
  output fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign head_job   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/upsm_front.sv
// ----------------------------------------------------------------------------
// upsm_front
// Converts frames to mono, holds each value until its successor arrives and
// queues interpolation jobs.
// ----------------------------------------------------------------------------
module upsm_front import upsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  fifo_stat_t stat,
  output logic       push,
  output job_t       push_job
);

  logic signed [15:0] held_value_r, held_value_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic signed [15:0] tail_mono_r,  tail_mono_nxt;
  logic               tail_valid_r, tail_valid_nxt;

  logic signed [15:0] pcm_l, pcm_r, mono;
  logic signed [16:0] pair_sum;
  logic signed [16:0] pair_adj;
  logic               accept;

  function automatic logic signed [15:0] to_pcm(input logic [15:0] raw, input logic wide);
    if (wide) begin
      return raw;
    end
    return {raw[7:0] ^ SIGN_FLIP_8, 8'h00};
  endfunction

  always_comb begin
    pcm_l    = to_pcm(in_data.left_raw, cfg.sixteen_bit);
    pcm_r    = to_pcm(in_data.right_raw, cfg.sixteen_bit);
    pair_sum = 17'(pcm_l) + 17'(pcm_r);
    // halve toward zero
    pair_adj = pair_sum + {16'd0, pair_sum[16]};
    mono     = cfg.stereo ? 16'(pair_adj >>> 1) : pcm_l;
  end

  assign in_ready = !tail_valid_r && !stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_value_nxt = held_value_r;
    held_valid_nxt = held_valid_r;
    tail_mono_nxt  = tail_mono_r;
    tail_valid_nxt = tail_valid_r;
    push           = 1'b0;
    push_job       = '0;
    if (tail_valid_r) begin
      // closing expansion of the clip, successor taken as zero
      if (!stat.full) begin
        push           = 1'b1;
        push_job.cur   = tail_mono_r;
        push_job.nxt   = '0;
        push_job.done  = 1'b1;
        tail_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (held_valid_r) begin
        push          = 1'b1;
        push_job.cur  = held_value_r;
        push_job.nxt  = mono;
        push_job.done = 1'b0;
      end
      if (in_data.clip_last) begin
        held_valid_nxt = 1'b0;
        held_value_nxt = '0;
        if (held_valid_r) begin
          tail_valid_nxt = 1'b1;
          tail_mono_nxt  = mono;
        end else begin
          push          = 1'b1;
          push_job.cur  = mono;
          push_job.nxt  = '0;
          push_job.done = 1'b1;
        end
      end else begin
        held_valid_nxt = 1'b1;
        held_value_nxt = mono;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_value_r <= '0;
      tail_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_value_r <= held_value_nxt;
      tail_valid_r <= tail_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_mono_r <= tail_mono_nxt;
  end

endmodule

// File: rtl/upsm_back.sv
// ----------------------------------------------------------------------------
// upsm_back
// Expands queued jobs into 1, 2 or 4 interpolated samples, one per cycle when
// not stalled, scales to quarter volume and drives the output register.
// ----------------------------------------------------------------------------
module upsm_back import upsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  job_t       head_job,
  input  fifo_stat_t stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic               active_r,  active_nxt;
  logic signed [15:0] v_r,       v_nxt;
  logic        [15:0] delta_r,   delta_nxt;
  logic        [2:0]  rem_r,     rem_nxt;
  logic               done_r,    done_nxt;
  logic               ovalid_r,  ovalid_nxt;
  out_item_t          odata_r,   odata_nxt;

  logic               emit, load;
  logic signed [16:0] diff, diff_adj;
  logic        [15:0] load_delta;
  logic        [2:0]  load_steps;
  logic signed [16:0] v_adj;

  // step count and truncating division of the successor difference
  always_comb begin
    diff = 17'(head_job.nxt) - 17'(head_job.cur);
    case (cfg.rate_select)
      RATE_44100: begin
        load_steps = 3'd1;
        diff_adj   = diff;
        load_delta = diff[15:0];
      end
      RATE_22050: begin
        load_steps = 3'd2;
        diff_adj   = diff + {16'd0, diff[16]};
        load_delta = 16'(diff_adj >>> 1);
      end
      default: begin
        load_steps = 3'd4;
        diff_adj   = diff + (diff[16] ? 17'sd3 : 17'sd0);
        load_delta = 16'(diff_adj >>> 2);
      end
    endcase
  end

  assign emit = active_r && (!ovalid_r || out_ready);
  assign load = !stat.empty && (!active_r || (emit && rem_r == 3'd1));
  assign pop  = load;

  // quarter volume, toward zero
  assign v_adj = 17'(v_r) + (v_r[15] ? 17'sd3 : 17'sd0);

  always_comb begin
    active_nxt = active_r;
    v_nxt      = v_r;
    delta_nxt  = delta_r;
    rem_nxt    = rem_r;
    done_nxt   = done_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (emit) begin
      ovalid_nxt          = 1'b1;
      odata_nxt.audio_out = 14'(v_adj >>> 2);
      odata_nxt.clip_done = done_r && (rem_r == 3'd1);
      if (rem_r == 3'd1) begin
        active_nxt = 1'b0;
      end else begin
        v_nxt   = v_r + delta_r;
        rem_nxt = rem_r - 1'b1;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      v_nxt      = head_job.cur;
      delta_nxt  = load_delta;
      rem_nxt    = load_steps;
      done_nxt   = head_job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    delta_r <= delta_nxt;
    rem_r   <= rem_nxt;
    done_r  <= done_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule

// File: rtl/pcm_to_mono_upsampler_top.sv
// ----------------------------------------------------------------------------
// pcm_to_mono_upsampler_top
// PCM frames in, 44.1 kHz mono samples at quarter volume out, by linear
// interpolation of each held value towards its successor.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_ready  | in_item_t: left, right, last
//   out_    | output    | out_valid/out_ready| out_item_t: sample, clip done
//   cfg_    | input     | cfg_we (no wait)   | cfg_idx, cfg_wdata
//
// A frame yields 1, 2 or 4 samples (the step of rate_select), the back end
// emitting one per cycle when not stalled; the final frame of a clip adds a
// second expansion. Front accepts while the job queue has room and no closing
// job is pending. Reset is synchronous, active low; it restores register
// defaults and drops any held value. Output stalls back up through the queue.
// ----------------------------------------------------------------------------
module pcm_to_mono_upsampler_top import upsm_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  fifo_stat_t stat;
  logic       push, pop;
  job_t       push_job, head_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SIXTEEN_BIT: cfg_nxt.sixteen_bit = cfg_wdata[0];
        CFG_STEREO:      cfg_nxt.stereo      = cfg_wdata[0];
        CFG_RATE_SELECT: cfg_nxt.rate_select = cfg_wdata[1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sixteen_bit <= 1'b1;
      cfg_r.stereo      <= 1'b0;
      cfg_r.rate_select <= RATE_44100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  upsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .push_job (push_job)
  );

  upsm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  upsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head_job  (head_job),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
